### rtl/core/tps_pkg.sv
// Shared constants, types and board tables for the tile puzzle shuffle generator.
package tps_pkg;

   localparam int MAX_CELLS = 36;
   localparam int IDX_W     = $clog2(MAX_CELLS);
   localparam int CELL_W    = 6;
   localparam int FIELD_W   = 6;
   localparam int SEED_W    = 15;

   localparam logic [31:0] LCG_MUL = 32'd214013;
   localparam logic [31:0] LCG_ADD = 32'd2531011;

   localparam int RAND_BITS = 15;
   localparam int DIGIT_W   = 5;
   localparam int DIV_STEPS = RAND_BITS / DIGIT_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [FIELD_W-1:0] COUNT8  = 6'd8;
   localparam logic [FIELD_W-1:0] COUNT15 = 6'd15;
   localparam logic [FIELD_W-1:0] COUNT24 = 6'd24;
   localparam logic [FIELD_W-1:0] COUNT35 = 6'd35;

   localparam logic [FIELD_W-1:0] SQ8 [9] = '{6'd1, 6'd2, 6'd3, 6'd4, 6'd0, 6'd8, 6'd7, 6'd6,
                                              6'd5};
   localparam logic [FIELD_W-1:0] SQ15 [16] = '{
      6'd1, 6'd2, 6'd3, 6'd4, 6'd8, 6'd7, 6'd6, 6'd5,
      6'd9, 6'd10, 6'd11, 6'd12, 6'd16, 6'd15, 6'd14, 6'd13};
   localparam logic [FIELD_W-1:0] SQ24 [25] = '{
      6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd10, 6'd9, 6'd8, 6'd7, 6'd6,
      6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd20, 6'd19, 6'd18, 6'd17, 6'd16,
      6'd21, 6'd22, 6'd23, 6'd24, 6'd25};
   localparam logic [FIELD_W-1:0] SQ35 [36] = '{
      6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd12, 6'd11, 6'd10, 6'd9, 6'd8, 6'd7,
      6'd13, 6'd14, 6'd15, 6'd16, 6'd17, 6'd18, 6'd24, 6'd23, 6'd22, 6'd21, 6'd20, 6'd19,
      6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd36, 6'd35, 6'd34, 6'd33, 6'd32, 6'd31};

   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  addr;
      logic [CELL_W-1:0] data;
   } cell_wr_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr_a;
      logic [IDX_W-1:0] addr_b;
   } cell_rd_type;

   typedef struct packed {
      logic               load;
      logic [SEED_W-1:0]  seed;
      logic               start;
      logic [FIELD_W-1:0] divisor;
   } rand_ctl_type;

   typedef struct packed {
      logic               done;
      logic [FIELD_W-1:0] pick;
   } rand_res_type;

   function automatic logic [FIELD_W-1:0] square_of(input logic [FIELD_W-1:0] n,
                                                    input logic [FIELD_W-1:0] idx);
      logic [FIELD_W-1:0] sq;
      sq = '0;
      if (n == COUNT15 && idx < 6'd16) begin
         sq = SQ15[idx[3:0]];
      end else if (n == COUNT24 && idx < 6'd25) begin
         sq = SQ24[idx[4:0]];
      end else if (n == COUNT35 && idx < 6'd36) begin
         sq = SQ35[idx];
      end else if (idx < 6'd9) begin
         sq = SQ8[idx[3:0]];
      end
      return sq;
   endfunction

endpackage

### rtl/core/tps_rand.sv
// Linear congruential generator with a five-bits-per-cycle remainder unit.
module tps_rand (
   input  logic                  clock,
   input  logic                  reset,
   input  tps_pkg::rand_ctl_type ctl,
   output tps_pkg::rand_res_type res
);

   typedef enum logic {R_IDLE, R_DIV} rand_state_type;

   rand_state_type                     state_ff;
   logic [31:0]                        gen_ff;
   logic [tps_pkg::DIV_CNT_W-1:0]      cnt_ff;
   logic [tps_pkg::RAND_BITS-1:0]      bits_ff;
   logic [tps_pkg::FIELD_W-1:0]        rem_ff;
   logic [tps_pkg::FIELD_W-1:0]        div_ff;
   logic                               done_ff;
   logic [tps_pkg::FIELD_W-1:0]        pick_ff;

   logic [tps_pkg::RAND_BITS-1:0]      src;
   logic [tps_pkg::FIELD_W-1:0]        rem_in;

   function automatic logic [tps_pkg::FIELD_W-1:0] rem_step(
      input logic [tps_pkg::FIELD_W-1:0] r,
      input logic                        b,
      input logic [tps_pkg::FIELD_W-1:0] d);
      logic [tps_pkg::FIELD_W:0] t;
      t = {r, b};
      if (t >= {1'b0, d}) begin
         t = t - {1'b0, d};
      end
      return t[tps_pkg::FIELD_W-1:0];
   endfunction

   // first digit comes straight from bits 30..16 of the fresh generator value
   always_comb begin
      src    = (cnt_ff == '0) ? gen_ff[30:16] : bits_ff;
      rem_in = (cnt_ff == '0) ? '0 : rem_ff;
      for (int k = 0; k < tps_pkg::DIGIT_W; k++) begin
         rem_in = rem_step(rem_in, src[tps_pkg::RAND_BITS-1-k], div_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= R_IDLE;
         gen_ff   <= '0;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         done_ff <= (state_ff == R_DIV) &&
                    (cnt_ff == tps_pkg::DIV_CNT_W'(tps_pkg::DIV_STEPS - 1));
         if (ctl.load) begin
            gen_ff <= 32'(ctl.seed);
         end
         case (state_ff)
            R_IDLE: begin
               if (ctl.start) begin
                  gen_ff   <= 32'(gen_ff * tps_pkg::LCG_MUL + tps_pkg::LCG_ADD);
                  div_ff   <= ctl.divisor;
                  cnt_ff   <= '0;
                  state_ff <= R_DIV;
               end
            end
            R_DIV: begin
               rem_ff  <= rem_in;
               bits_ff <= tps_pkg::RAND_BITS'(src << tps_pkg::DIGIT_W);
               cnt_ff  <= cnt_ff + 1'b1;
               if (cnt_ff == tps_pkg::DIV_CNT_W'(tps_pkg::DIV_STEPS - 1)) begin
                  pick_ff  <= rem_in;
                  state_ff <= R_IDLE;
               end
            end
            default: state_ff <= R_IDLE;
         endcase
      end
   end

   assign res.done = done_ff;
   assign res.pick = pick_ff;

endmodule

### rtl/core/tps_cell_store.sv
// Cell table: one write port, two registered read ports.
module tps_cell_store (
   input  logic                         clock,
   input  tps_pkg::cell_wr_type         wr,
   input  tps_pkg::cell_rd_type         rd,
   output logic [tps_pkg::CELL_W-1:0]   rd_data_a,
   output logic [tps_pkg::CELL_W-1:0]   rd_data_b
);

   logic [tps_pkg::CELL_W-1:0] mem [tps_pkg::MAX_CELLS];
   logic [tps_pkg::CELL_W-1:0] rd_a_ff;
   logic [tps_pkg::CELL_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_a_ff <= mem[rd.addr_a];
         rd_b_ff <= mem[rd.addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

### rtl/core/tile_puzzle_shuffle_generator_core.sv
// Top level: request sequencer for fill, shuffle, parity fix and cell output.
//
//   channel | direction | handshake            | fields
//   req     | in        | req_valid/req_stall  | seed, tile_count, want_odd
//   rsp     | out       | rsp_valid/rsp_stall  | cell_index, square, tile, last
//
// A request of n tiles runs as: accept, n+1 fill writes, then per shuffle step the
// generator advance, the remainder digits, a read and two writes (only when the pick
// differs), up to the parity fix, and per output word a read and a load.
// Synchronous reset returns the sequencer to idle; the cell table is not cleared.
// req_stall is low only while idle; a stalled output word holds and the next
// read waits for the output register to free.
module tile_puzzle_shuffle_generator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [14:0] req_seed,
   input  logic [5:0]  req_tile_count,
   input  logic        req_want_odd,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_cell_index,
   output logic [5:0]  rsp_square,
   output logic [5:0]  rsp_tile,
   output logic        rsp_last
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_FILL, ST_STEP, ST_WAIT, ST_SWAP_A, ST_SWAP_B,
      ST_FIX, ST_EMIT_RD, ST_EMIT_LD
   } seq_state_type;

   seq_state_type               state_ff;
   logic [tps_pkg::FIELD_W-1:0] n_ff;
   logic                        want_ff;
   logic [tps_pkg::FIELD_W-1:0] idx_ff;
   logic [tps_pkg::FIELD_W-1:0] i_ff;
   logic [tps_pkg::FIELD_W-1:0] a_ff;
   logic [tps_pkg::FIELD_W-1:0] b_ff;
   logic                        par_ff;
   logic                        fix_ff;
   logic                        out_valid_ff;
   logic [5:0]                  out_index_ff;
   logic [5:0]                  out_square_ff;
   logic [5:0]                  out_tile_ff;
   logic                        out_last_ff;

   tps_pkg::rand_ctl_type       rand_ctl;
   tps_pkg::rand_res_type       rand_res;
   tps_pkg::cell_wr_type        cell_wr;
   tps_pkg::cell_rd_type        cell_rd;
   logic [tps_pkg::CELL_W-1:0]  data_a;
   logic [tps_pkg::CELL_W-1:0]  data_b;

   logic                        req_take;
   logic                        out_free;
   logic                        toggle;
   logic [tps_pkg::FIELD_W-1:0] n_norm;

   assign req_take = (state_ff == ST_IDLE) && req_valid;
   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      n_norm = tps_pkg::COUNT8;
      if ((req_tile_count == tps_pkg::COUNT15 || req_tile_count == tps_pkg::COUNT24 ||
           req_tile_count == tps_pkg::COUNT35) &&
          (int'(req_tile_count) + 1 <= tps_pkg::MAX_CELLS)) begin
         n_norm = req_tile_count;
      end
   end

   // parity changes for two tiles, or for the blank over an even distance
   assign toggle = (data_a != '0 && data_b != '0) || !(a_ff[0] ^ b_ff[0]);

   always_comb begin
      rand_ctl.load    = req_take;
      rand_ctl.seed    = req_seed;
      rand_ctl.start   = (state_ff == ST_STEP);
      rand_ctl.divisor = i_ff + 1'b1;

      cell_wr.en   = 1'b0;
      cell_wr.addr = tps_pkg::IDX_W'(idx_ff);
      cell_wr.data = tps_pkg::CELL_W'(idx_ff);
      cell_rd.en     = 1'b0;
      cell_rd.addr_a = tps_pkg::IDX_W'(i_ff);
      cell_rd.addr_b = tps_pkg::IDX_W'(rand_res.pick);
      case (state_ff)
         ST_FILL: cell_wr.en = 1'b1;
         ST_WAIT: cell_rd.en = rand_res.done && (rand_res.pick != i_ff);
         ST_SWAP_A: begin
            cell_wr.en   = 1'b1;
            cell_wr.addr = tps_pkg::IDX_W'(a_ff);
            cell_wr.data = data_b;
         end
         ST_SWAP_B: begin
            cell_wr.en   = 1'b1;
            cell_wr.addr = tps_pkg::IDX_W'(b_ff);
            cell_wr.data = data_a;
         end
         ST_FIX: begin
            cell_rd.en     = (par_ff != want_ff);
            cell_rd.addr_a = '0;
            cell_rd.addr_b = tps_pkg::IDX_W'(2);
         end
         ST_EMIT_RD: begin
            cell_rd.en     = out_free;
            cell_rd.addr_a = tps_pkg::IDX_W'(idx_ff);
         end
         default: ;
      endcase
   end

   tps_rand u_rand (
      .clock (clock),
      .reset (reset),
      .ctl   (rand_ctl),
      .res   (rand_res)
   );

   tps_cell_store u_cells (
      .clock     (clock),
      .wr        (cell_wr),
      .rd        (cell_rd),
      .rd_data_a (data_a),
      .rd_data_b (data_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         par_ff       <= 1'b0;
         fix_ff       <= 1'b0;
      end else begin
         if (out_valid_ff && !rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  n_ff     <= n_norm;
                  want_ff  <= req_want_odd;
                  idx_ff   <= '0;
                  state_ff <= ST_FILL;
               end
            end
            ST_FILL: begin
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff == n_ff) begin
                  i_ff     <= n_ff;
                  par_ff   <= 1'b0;
                  fix_ff   <= 1'b0;
                  state_ff <= ST_STEP;
               end
            end
            ST_STEP: state_ff <= ST_WAIT;
            ST_WAIT: begin
               if (rand_res.done) begin
                  a_ff <= i_ff;
                  b_ff <= rand_res.pick;
                  if (rand_res.pick != i_ff) begin
                     state_ff <= ST_SWAP_A;
                  end else if (i_ff == 6'd1) begin
                     state_ff <= ST_FIX;
                  end else begin
                     i_ff     <= i_ff - 1'b1;
                     state_ff <= ST_STEP;
                  end
               end
            end
            ST_SWAP_A: begin
               if (!fix_ff && toggle) begin
                  par_ff <= !par_ff;
               end
               state_ff <= ST_SWAP_B;
            end
            ST_SWAP_B: begin
               if (fix_ff) begin
                  idx_ff   <= '0;
                  state_ff <= ST_EMIT_RD;
               end else if (i_ff == 6'd1) begin
                  state_ff <= ST_FIX;
               end else begin
                  i_ff     <= i_ff - 1'b1;
                  state_ff <= ST_STEP;
               end
            end
            ST_FIX: begin
               if (par_ff != want_ff) begin
                  fix_ff   <= 1'b1;
                  a_ff     <= '0;
                  b_ff     <= 6'd2;
                  state_ff <= ST_SWAP_A;
               end else begin
                  idx_ff   <= '0;
                  state_ff <= ST_EMIT_RD;
               end
            end
            ST_EMIT_RD: begin
               if (out_free) begin
                  state_ff <= ST_EMIT_LD;
               end
            end
            ST_EMIT_LD: begin
               out_valid_ff  <= 1'b1;
               out_index_ff  <= idx_ff;
               out_square_ff <= tps_pkg::square_of(n_ff, idx_ff);
               out_tile_ff   <= data_a;
               out_last_ff   <= (idx_ff == n_ff);
               if (idx_ff == n_ff) begin
                  state_ff <= ST_IDLE;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= ST_EMIT_RD;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = out_valid_ff;
   assign rsp_cell_index = out_index_ff;
   assign rsp_square     = out_square_ff;
   assign rsp_tile       = out_tile_ff;
   assign rsp_last       = out_last_ff;

endmodule

### test/shuffle_board_checker.sv
// Checker for the shuffle generator: predicts each board and compares every output word.
`timescale 1ns / 100ps

module shuffle_board_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic [tps_pkg::SEED_W-1:0]  req_seed,
   input  logic [tps_pkg::FIELD_W-1:0] req_tile_count,
   input  logic                        req_want_odd,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic [tps_pkg::FIELD_W-1:0] rsp_cell_index,
   input  logic [tps_pkg::FIELD_W-1:0] rsp_square,
   input  logic [tps_pkg::FIELD_W-1:0] rsp_tile,
   input  logic                        rsp_last,
   output int                          mismatch_count,
   output int                          cells_pending
);

   localparam logic [31:0] GEN_MUL  = 32'd214013;
   localparam logic [31:0] GEN_ADD  = 32'd2531011;
   localparam logic [31:0] GEN_MASK = 32'h0000_7FFF;

   // the 3x3 board does not follow the serpentine rule
   localparam logic [tps_pkg::FIELD_W-1:0] EIGHT_SQUARES [9] = '{
      6'd1, 6'd2, 6'd3, 6'd4, 6'd0, 6'd8, 6'd7, 6'd6, 6'd5};

   typedef struct packed {
      logic [tps_pkg::FIELD_W-1:0] cell_index;
      logic [tps_pkg::FIELD_W-1:0] square;
      logic [tps_pkg::FIELD_W-1:0] tile;
      logic                        last;
   } board_cell_type;

   board_cell_type expected_cells[$];
   board_cell_type got_cell;
   board_cell_type want_cell;
   int             errors = 0;

   function automatic void predict_board(input logic [tps_pkg::SEED_W-1:0]  seed,
                                         input logic [tps_pkg::FIELD_W-1:0] count_in,
                                         input logic                        want_odd);
      logic [tps_pkg::FIELD_W-1:0] board [tps_pkg::MAX_CELLS];
      logic [31:0]                 gen;
      logic [tps_pkg::FIELD_W-1:0] n;
      logic [tps_pkg::FIELD_W-1:0] held;
      logic                        odd_swaps;
      int                          k;
      int                          pick;
      int                          side;
      int                          row;
      int                          col;
      board_cell_type              entry;
      n = count_in;
      if ((n != tps_pkg::COUNT8 && n != tps_pkg::COUNT15 && n != tps_pkg::COUNT24 &&
           n != tps_pkg::COUNT35) || int'(n) + 1 > tps_pkg::MAX_CELLS) begin
         n = tps_pkg::COUNT8;
      end
      gen = {17'd0, seed};
      for (k = 0; k <= int'(n); k++) begin
         board[k] = k[tps_pkg::FIELD_W-1:0];
      end
      odd_swaps = 1'b0;
      for (k = int'(n); k > 0; k--) begin
         gen  = gen * GEN_MUL + GEN_ADD;
         pick = int'((gen >> 16) & GEN_MASK) % (k + 1);
         if (pick != k) begin
            held        = board[k];
            board[k]    = board[pick];
            board[pick] = held;
            // a move of the blank changes parity only across an even distance
            if (board[k] != '0 && board[pick] != '0) begin
               odd_swaps = ~odd_swaps;
            end else if (((k - pick) % 2) == 0) begin
               odd_swaps = ~odd_swaps;
            end
         end
      end
      if (odd_swaps != want_odd) begin
         held     = board[0];
         board[0] = board[2];
         board[2] = held;
      end
      case (n)
         tps_pkg::COUNT15: side = 4;
         tps_pkg::COUNT24: side = 5;
         default: side = 6;
      endcase
      for (k = 0; k <= int'(n); k++) begin
         row              = k / side;
         col              = k % side;
         entry.cell_index = k[tps_pkg::FIELD_W-1:0];
         if (n == tps_pkg::COUNT8) begin
            entry.square = EIGHT_SQUARES[k];
         end else if (row % 2 == 1) begin
            entry.square = tps_pkg::FIELD_W'(row * side + side - col);
         end else begin
            entry.square = tps_pkg::FIELD_W'(row * side + col + 1);
         end
         entry.tile = board[k];
         entry.last = (k == int'(n));
         expected_cells.push_back(entry);
      end
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got_cell = {rsp_cell_index, rsp_square, rsp_tile, rsp_last};
            if (expected_cells.size() == 0) begin
               $display("%0t: unexpected word: index %0d square %0d tile %0d last %0d",
                        $time, got_cell.cell_index, got_cell.square, got_cell.tile,
                        got_cell.last);
               errors++;
            end else begin
               want_cell = expected_cells.pop_front();
               if (got_cell !== want_cell) begin
                  $display("%0t: expected %0d/%0d/%0d/%0d actual %0d/%0d/%0d/%0d",
                           $time, want_cell.cell_index, want_cell.square, want_cell.tile,
                           want_cell.last, got_cell.cell_index, got_cell.square,
                           got_cell.tile, got_cell.last);
                  errors++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            predict_board(req_seed, req_tile_count, req_want_odd);
         end
      end
      mismatch_count <= errors;
      cells_pending  <= expected_cells.size();
   end

endmodule

### test/tile_puzzle_shuffle_generator_core_test.sv
// Testbench top: drives requests and output stalls around the shuffle generator core.
`timescale 1ns / 100ps

module tile_puzzle_shuffle_generator_core_test;

   localparam int STUCK_LIMIT = 4000;
   localparam int HOLD_CYCLES = 400;

   logic                        clock          = 1'b0;
   logic                        reset          = 1'b1;
   logic                        req_valid      = 1'b0;
   logic                        req_stall;
   logic [tps_pkg::SEED_W-1:0]  req_seed       = '0;
   logic [tps_pkg::FIELD_W-1:0] req_tile_count = '0;
   logic                        req_want_odd   = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_stall      = 1'b0;
   logic [tps_pkg::FIELD_W-1:0] rsp_cell_index;
   logic [tps_pkg::FIELD_W-1:0] rsp_square;
   logic [tps_pkg::FIELD_W-1:0] rsp_tile;
   logic                        rsp_last;

   int   mismatch_count;
   int   cells_pending;
   int   req_idle_pct = 0;
   int   rsp_idle_pct = 0;
   logic hold_arm     = 1'b0;
   logic hold_taken   = 1'b0;
   int   hold_left    = 0;
   int   stuck_cycles = 0;

   tile_puzzle_shuffle_generator_core u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_seed       (req_seed),
      .req_tile_count (req_tile_count),
      .req_want_odd   (req_want_odd),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cell_index (rsp_cell_index),
      .rsp_square     (rsp_square),
      .rsp_tile       (rsp_tile),
      .rsp_last       (rsp_last)
   );

   shuffle_board_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_seed       (req_seed),
      .req_tile_count (req_tile_count),
      .req_want_odd   (req_want_odd),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cell_index (rsp_cell_index),
      .rsp_square     (rsp_square),
      .rsp_tile       (rsp_tile),
      .rsp_last       (rsp_last),
      .mismatch_count (mismatch_count),
      .cells_pending  (cells_pending)
   );

   always #1 clock = ~clock;

   // output side: random stalls, plus one long hold once armed
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_arm && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_stall  <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, STUCK_LIMIT);
         $display("tile_puzzle_shuffle_generator_core_test: FAIL");
         $finish;
      end
   end

   task automatic send_request(input logic [tps_pkg::SEED_W-1:0]  seed,
                               input logic [tps_pkg::FIELD_W-1:0] count,
                               input logic                        odd);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_seed       <= seed;
      req_tile_count <= count;
      req_want_odd   <= odd;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_random(input int items);
      logic [tps_pkg::SEED_W-1:0]  seed;
      logic [tps_pkg::FIELD_W-1:0] count;
      int                          roll;
      for (int i = 0; i < items; i++) begin
         roll = $urandom_range(19);
         if (roll == 0) begin
            seed = '0;
         end else if (roll == 1) begin
            seed = '1;
         end else begin
            seed = tps_pkg::SEED_W'($urandom_range(32767));
         end
         // mostly legal board sizes, the rest anything the field holds
         if ($urandom_range(9) < 7) begin
            case ($urandom_range(3))
               0: count = tps_pkg::COUNT8;
               1: count = tps_pkg::COUNT15;
               2: count = tps_pkg::COUNT24;
               default: count = tps_pkg::COUNT35;
            endcase
         end else begin
            count = tps_pkg::FIELD_W'($urandom_range(63));
         end
         send_request(seed, count, 1'($urandom_range(1)));
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset        <= 1'b0;
      req_idle_pct = 38;
      rsp_idle_pct <= 66;
      @(posedge clock);

      // board sizes, seed extremes, both parities, unsupported counts
      send_request(15'd0,     tps_pkg::COUNT8,  1'b0);
      send_request(15'd32767, tps_pkg::COUNT35, 1'b1);
      send_request(15'd0,     tps_pkg::COUNT35, 1'b0);
      send_request(15'd32767, tps_pkg::COUNT8,  1'b1);
      send_request(15'd12345, tps_pkg::COUNT15, 1'b0);
      send_request(15'd12345, tps_pkg::COUNT15, 1'b1);
      send_request(15'd777,   tps_pkg::COUNT24, 1'b0);
      send_request(15'd777,   tps_pkg::COUNT24, 1'b1);
      send_request(15'd1,     tps_pkg::COUNT15, 1'b1);
      send_request(15'd16384, tps_pkg::COUNT24, 1'b0);
      send_request(15'd100,   6'd0,    1'b1);
      send_request(15'd101,   6'd63,   1'b0);
      send_request(15'd102,   6'd36,   1'b1);
      send_request(15'd103,   6'd9,    1'b0);
      send_request(15'd104,   6'd34,   1'b1);
      send_request(15'd105,   6'd16,   1'b0);
      send_random(110);

      req_idle_pct = 66;
      rsp_idle_pct <= 38;
      send_random(120);

      // no idling; the long output hold backs the block up into its input
      req_idle_pct = 0;
      rsp_idle_pct <= 0;
      hold_arm     <= 1'b1;
      send_random(120);

      req_valid <= 1'b0;
      @(posedge clock);
      while (cells_pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tile_puzzle_shuffle_generator_core_test: PASS");
      end else begin
         $display("tile_puzzle_shuffle_generator_core_test: FAIL");
      end
      $finish;
   end

endmodule
